FILE: src/ble_pkg.sv
package ble_pkg;

    // Default list depth handed to the top level.
    localparam int DEPTH_DEFAULT = 16;

    localparam int DATA_W = 32;

    // Command codes carried in the command field of an input word.
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_FIND       = 3'd3;
    localparam logic [2:0] CMD_REVERSE    = 3'd4;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] item_value;
    } t_ble_in;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] popped_value;
        logic                     found;
        logic [3:0]               found_index;
        logic [4:0]               entry_count;
        logic                     is_empty;
    } t_ble_out;

    // Operations the controller asks of the datapath in one cycle.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH_FRONT,
        DP_PUSH_BACK,
        DP_POP_READ,
        DP_POP_DONE,
        DP_FIND_INIT,
        DP_FIND_STEP,
        DP_FIND_HIT,
        DP_REVERSE,
        DP_REPORT
    } t_dp_op;

    // Status the datapath returns to the controller.
    typedef struct packed {
        logic [2:0] command;
        logic       empty;
        logic       find_hit;
        logic       find_exhausted;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_WAIT,
        ST_FIND_RUN
    } t_state;

endpackage

FILE: src/ble_dp.sv
module ble_dp #(
    parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ble_pkg::t_dp_op     i_op,
    input  ble_pkg::t_ble_in    i_cmd_word,
    output ble_pkg::t_dp_status o_status,
    output ble_pkg::t_ble_out   o_result_word,
    output logic                o_result_strobe
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0] DEPTH_W = (PW + 1)'(DEPTH);

    // Entry store: one write port, one registered read port.
    logic [ble_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [ble_pkg::DATA_W-1:0] r_rdata;

    logic [PW-1:0]              r_head, n_head;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_rev, n_rev;
    logic [2:0]                 r_cmd;
    logic [ble_pkg::DATA_W-1:0] r_val;
    logic [PW-1:0]              r_walk, n_walk;
    logic [CW-1:0]              r_issue_idx, n_issue_idx;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [PW-1:0]              r_cmp_idx, n_cmp_idx;
    ble_pkg::t_ble_out          r_res, n_res;
    logic                       r_res_vld, n_res_vld;

    logic          wr_en, rd_en;
    logic [PW-1:0] wr_addr, rd_addr;
    logic          full, empty, issue_done, hit;
    logic [PW-1:0] pos_sel, slot_pos;
    logic [PW:0]   sum_fwd, diff_rev;

    function automatic logic [PW-1:0] step_up(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] step_down(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
    endfunction

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign issue_done = (r_issue_idx == r_count);
    assign hit        = r_cmp_vld && (r_rdata == r_val);

    // Physical slot of a logical position, forward or reversed.
    assign pos_sel  = (i_op == ble_pkg::DP_REVERSE) ? PW'(r_count - CW'(1)) : PW'(r_count);
    assign sum_fwd  = {1'b0, r_head} + {1'b0, pos_sel};
    assign diff_rev = {1'b0, r_head} - {1'b0, pos_sel};
    assign slot_pos = r_rev ? (diff_rev[PW] ? PW'(diff_rev + DEPTH_W) : PW'(diff_rev))
                            : ((sum_fwd >= DEPTH_W) ? PW'(sum_fwd - DEPTH_W) : PW'(sum_fwd));

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_rev       = r_rev;
        n_walk      = r_walk;
        n_issue_idx = r_issue_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_res       = '0;
        n_res_vld   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_head;
        rd_en       = 1'b0;
        rd_addr     = r_head;

        unique case (i_op)
            ble_pkg::DP_PUSH_FRONT: begin
                n_res_vld = 1'b1;
                if (!full) begin
                    if (!empty) begin
                        n_head = r_rev ? step_up(r_head) : step_down(r_head);
                    end
                    wr_en    = 1'b1;
                    wr_addr  = n_head;
                    n_count  = r_count + CW'(1);
                    n_res.ok = 1'b1;
                end
            end
            ble_pkg::DP_PUSH_BACK: begin
                n_res_vld = 1'b1;
                if (!full) begin
                    wr_en    = 1'b1;
                    wr_addr  = slot_pos;
                    n_count  = r_count + CW'(1);
                    n_res.ok = 1'b1;
                end
            end
            ble_pkg::DP_POP_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
            end
            ble_pkg::DP_POP_DONE: begin
                n_res_vld          = 1'b1;
                n_res.ok           = 1'b1;
                n_res.popped_value = r_rdata;
                n_count            = r_count - CW'(1);
                if (n_count != '0) begin
                    n_head = r_rev ? step_down(r_head) : step_up(r_head);
                end
            end
            ble_pkg::DP_FIND_INIT: begin
                n_walk      = r_head;
                n_issue_idx = '0;
            end
            ble_pkg::DP_FIND_STEP: begin
                if (!issue_done) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_walk;
                    n_walk      = r_rev ? step_down(r_walk) : step_up(r_walk);
                    n_issue_idx = r_issue_idx + CW'(1);
                    n_cmp_vld   = 1'b1;
                    n_cmp_idx   = PW'(r_issue_idx);
                end
            end
            ble_pkg::DP_FIND_HIT: begin
                n_res_vld         = 1'b1;
                n_res.found       = 1'b1;
                n_res.found_index = 4'(r_cmp_idx);
            end
            ble_pkg::DP_REVERSE: begin
                n_res_vld = 1'b1;
                if (!empty) begin
                    n_head = slot_pos;
                end
                n_rev = ~r_rev;
            end
            ble_pkg::DP_REPORT: begin
                n_res_vld = 1'b1;
            end
            default: begin
            end
        endcase

        n_res.entry_count = 5'(n_count);
        n_res.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_rev     <= n_rev;
            r_cmp_vld <= n_cmp_vld;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == ble_pkg::DP_LOAD) begin
            r_cmd <= i_cmd_word.command;
            r_val <= i_cmd_word.item_value;
        end
        r_walk      <= n_walk;
        r_issue_idx <= n_issue_idx;
        r_cmp_idx   <= n_cmp_idx;
        if (n_res_vld) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_status.command        = r_cmd;
    assign o_status.empty          = empty;
    assign o_status.find_hit       = hit;
    assign o_status.find_exhausted = issue_done && !r_cmp_vld;

    assign o_result_word   = r_res;
    assign o_result_strobe = r_res_vld;

endmodule

FILE: src/ble_ctrl.sv
module ble_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ble_pkg::t_dp_status i_status,
    output logic                o_busy,
    output ble_pkg::t_dp_op     o_op
);

    ble_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ble_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = ble_pkg::DP_NOP;
        o_busy  = 1'b1;

        unique case (r_state)
            ble_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_op    = ble_pkg::DP_LOAD;
                    n_state = ble_pkg::ST_EXEC;
                end
            end
            ble_pkg::ST_EXEC: begin
                n_state = ble_pkg::ST_IDLE;
                unique case (i_status.command)
                    ble_pkg::CMD_PUSH_FRONT: o_op = ble_pkg::DP_PUSH_FRONT;
                    ble_pkg::CMD_PUSH_BACK:  o_op = ble_pkg::DP_PUSH_BACK;
                    ble_pkg::CMD_POP_FRONT: begin
                        if (i_status.empty) begin
                            o_op = ble_pkg::DP_REPORT;
                        end else begin
                            o_op    = ble_pkg::DP_POP_READ;
                            n_state = ble_pkg::ST_POP_WAIT;
                        end
                    end
                    ble_pkg::CMD_FIND: begin
                        o_op    = ble_pkg::DP_FIND_INIT;
                        n_state = ble_pkg::ST_FIND_RUN;
                    end
                    ble_pkg::CMD_REVERSE: o_op = ble_pkg::DP_REVERSE;
                    default:              o_op = ble_pkg::DP_REPORT;
                endcase
            end
            ble_pkg::ST_POP_WAIT: begin
                o_op    = ble_pkg::DP_POP_DONE;
                n_state = ble_pkg::ST_IDLE;
            end
            ble_pkg::ST_FIND_RUN: begin
                priority if (i_status.find_hit) begin
                    o_op    = ble_pkg::DP_FIND_HIT;
                    n_state = ble_pkg::ST_IDLE;
                end else if (i_status.find_exhausted) begin
                    o_op    = ble_pkg::DP_REPORT;
                    n_state = ble_pkg::ST_IDLE;
                end else begin
                    o_op = ble_pkg::DP_FIND_STEP;
                end
            end
            default: begin
                n_state = ble_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/bounded_list_engine_top.sv
// Bounded list engine: an ordered list of signed 32-bit values, at most DEPTH
// entries deep, kept in a ring store with a head pointer, a count and a
// direction flag. Commands push at the front, push at the back, pop the front,
// find the first position of a value, or reverse the order.
// A command word is taken at a rising edge where start is high and busy is low.
// Exactly one result word follows for each command; it sits on o_result_word
// for one cycle while o_result_strobe is high. The receiver cannot stall, so
// the result is never held; busy is already low in the strobe cycle, so the
// next command may be given while a result is shown.
// Push, reverse, unused codes and a pop of an empty list finish in the execute
// state; other pops add a pop-wait state for one registered read of the entry
// store. Find ends at the first match, or once every entry has been compared;
// on an empty list it reports without a read. Find walks the entries one per
// cycle through the single read port of the store, with the compare in the
// cycle after each read. The result strobe comes in the cycle after the last
// working cycle.
// Synchronous reset empties the list (count, head and direction cleared) and
// returns the controller to idle; the store contents are not cleared, since an
// entry is never read before it is written.
module bounded_list_engine_top #(
    parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ble_pkg::t_ble_in  i_cmd_word,
    output ble_pkg::t_ble_out o_result_word,
    output logic              o_result_strobe
);

    ble_pkg::t_dp_op     dp_op;
    ble_pkg::t_dp_status dp_status;

    // Controller sequences each command as a few datapath operations.
    ble_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_op     (dp_op)
    );

    // Datapath holds the pointers, the entry store and the result register.
    ble_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (dp_op),
        .i_cmd_word      (i_cmd_word),
        .o_status        (dp_status),
        .o_result_word   (o_result_word),
        .o_result_strobe (o_result_strobe)
    );

endmodule

FILE: verif/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // The list depth matches the default that the block is built with.
    localparam int LIST_DEPTH = ble_pkg::DEPTH_DEFAULT;

    // Codes 5 to 7 are not commands. The block must answer them without
    // touching the list.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    localparam logic [31:0] VALUE_MAX = 32'h7fff_ffff;
    localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

    // Clock period is 20 ns, so even a long run ends well inside this limit.
    localparam int RUN_LIMIT_NS = 20_000_000;

    // A find on a full list is the slowest command. The tail wait covers it
    // with some margin.
    localparam int TAIL_CYCLES = LIST_DEPTH + 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    ble_pkg::t_ble_in   i_cmd_word = '0;
    ble_pkg::t_ble_out  o_result_word;
    logic               o_result_strobe;

    bounded_list_engine_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd_word      (i_cmd_word),
        .o_result_word   (o_result_word),
        .o_result_strobe (o_result_strobe)
    );

    // Our own copy of the list. It is a ring of slots with a head slot, an
    // entry count and a direction flag, just as the block keeps it.
    logic [31:0] list_store [LIST_DEPTH];
    int          head_slot = 0;
    int          list_count = 0;
    bit          is_reversed = 1'b0;

    // Result words that the list state predicts, oldest first.
    ble_pkg::t_ble_out pending_results [$];
    int                error_count = 0;

    // Number of words still to send in the current burst of the sender.
    int          burst_left = 1;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // This is the watchdog. A hung handshake or a missing result ends here.
    initial begin
        #(RUN_LIMIT_NS * 1ns);
        $display("Mismatches found");
        $finish;
    end

    function automatic int slot_up(int s);
        return (s + 1) % LIST_DEPTH;
    endfunction

    function automatic int slot_down(int s);
        return (s + LIST_DEPTH - 1) % LIST_DEPTH;
    endfunction

    // This maps a position, counted from the front, to its physical slot.
    // When the list is reversed, the front runs toward lower slots.
    function automatic int slot_at(int pos);
        if (is_reversed) begin
            return (head_slot + LIST_DEPTH - pos) % LIST_DEPTH;
        end
        return (head_slot + pos) % LIST_DEPTH;
    endfunction

    // This applies one accepted command word to our copy of the list. It
    // queues the result word that the block has to return for it.
    task automatic predict_list_result(input ble_pkg::t_ble_in word);
        ble_pkg::t_ble_out res;
        logic [31:0]       val;
        res = '0;
        val = word.item_value;
        case (word.command)
            ble_pkg::CMD_PUSH_FRONT: begin
                if (list_count < LIST_DEPTH) begin
                    // The first entry goes into the head slot itself.
                    if (list_count != 0) begin
                        head_slot = is_reversed ? slot_up(head_slot) : slot_down(head_slot);
                    end
                    list_store[head_slot] = val;
                    list_count++;
                    res.ok = 1'b1;
                end
            end
            ble_pkg::CMD_PUSH_BACK: begin
                if (list_count < LIST_DEPTH) begin
                    list_store[slot_at(list_count)] = val;
                    list_count++;
                    res.ok = 1'b1;
                end
            end
            ble_pkg::CMD_POP_FRONT: begin
                if (list_count != 0) begin
                    res.popped_value = list_store[head_slot];
                    list_count--;
                    if (list_count != 0) begin
                        head_slot = is_reversed ? slot_down(head_slot) : slot_up(head_slot);
                    end
                    res.ok = 1'b1;
                end
            end
            ble_pkg::CMD_FIND: begin
                for (int pos = 0; pos < list_count; pos++) begin
                    if (list_store[slot_at(pos)] == val) begin
                        res.found = 1'b1;
                        res.found_index = 4'(pos);
                        break;
                    end
                end
            end
            ble_pkg::CMD_REVERSE: begin
                // No data moves. The old last entry becomes the head, and the
                // direction flips even on an empty list.
                if (list_count != 0) begin
                    head_slot = slot_at(list_count - 1);
                end
                is_reversed = !is_reversed;
            end
            default: begin
            end
        endcase
        res.entry_count = 5'(list_count);
        res.is_empty = (list_count == 0);
        pending_results.push_back(res);
    endtask

    // The sender works in bursts. When a burst runs out, start drops for a
    // random gap. Junk sits on the command word during the gap, and the block
    // must ignore it.
    task automatic pace_sender();
        ble_pkg::t_ble_in noise;
        burst_left--;
        if (burst_left <= 0) begin
            noise.command = 3'($urandom());
            noise.item_value = $urandom();
            start <= 1'b0;
            i_cmd_word <= noise;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
        end
    endtask

    // This sends one command word. It is called at a rising edge. Within a burst,
    // start stays high from one word to the next, so back-to-back words need no gap.
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] val);
        ble_pkg::t_ble_in word;
        word.command = cmd;
        word.item_value = val;
        start <= 1'b1;
        i_cmd_word <= word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_list_result(word);
        pace_sender();
    endtask

    // Many values come from a narrow pool or from the list itself, so finds
    // hit and duplicates appear. The rest are extremes or fully random.
    function automatic logic [31:0] pick_value(int hit_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < hit_pct && list_count != 0) begin
            return list_store[slot_at($urandom_range(0, list_count - 1))];
        end
        if (roll < hit_pct + 25) begin
            return 32'($urandom_range(0, 8)) - 32'd4;
        end
        if (roll < hit_pct + 32) begin
            return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
        end
        return $urandom();
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Each result word is taken at the edge that ends its strobe cycle. It is
    // checked, field by field, against the oldest word still expected.
    always @(posedge i_clk) begin
        ble_pkg::t_ble_out exp_word;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word expected none actual %p", $time, o_result_word);
                error_count++;
            end else begin
                exp_word = pending_results.pop_front();
                check_field("ok", exp_word.ok, o_result_word.ok);
                check_field("popped_value", exp_word.popped_value,
                            o_result_word.popped_value);
                check_field("found", exp_word.found, o_result_word.found);
                check_field("found_index", exp_word.found_index,
                            o_result_word.found_index);
                check_field("entry_count", exp_word.entry_count,
                            o_result_word.entry_count);
                check_field("is_empty", exp_word.is_empty, o_result_word.is_empty);
            end
        end
    end

    // Pop, find, reverse and the unused codes 5 and 7 are tried on the empty list that
    // reset leaves.
    task automatic test_empty_list();
        send_word(ble_pkg::CMD_POP_FRONT, 32'd0);
        send_word(ble_pkg::CMD_FIND, 32'd0);
        send_word(ble_pkg::CMD_REVERSE, VALUE_MAX);
        send_word(CMD_UNUSED_FIRST, VALUE_MIN);
        send_word(CMD_UNUSED_LAST, 32'hffff_ffff);
        send_word(ble_pkg::CMD_REVERSE, 32'd0);
    endtask

    // The largest value goes in at the front and the smallest at the back. A few hits
    // and a miss follow, then a reverse, and after it pushes on a reversed list.
    task automatic test_extreme_values();
        send_word(ble_pkg::CMD_PUSH_FRONT, VALUE_MAX);
        send_word(ble_pkg::CMD_PUSH_BACK, VALUE_MIN);
        send_word(ble_pkg::CMD_PUSH_FRONT, 32'd0);
        send_word(ble_pkg::CMD_PUSH_BACK, 32'hffff_ffff);
        send_word(ble_pkg::CMD_FIND, VALUE_MIN);
        send_word(ble_pkg::CMD_FIND, 32'd12345);
        send_word(ble_pkg::CMD_FIND, 32'd0);
        send_word(ble_pkg::CMD_REVERSE, 32'd0);
        send_word(ble_pkg::CMD_FIND, 32'hffff_ffff);
        send_word(ble_pkg::CMD_POP_FRONT, 32'd0);
        send_word(CMD_UNUSED_FIRST + 3'd1, VALUE_MAX);
        send_word(ble_pkg::CMD_PUSH_FRONT, 32'd1);
        send_word(ble_pkg::CMD_PUSH_BACK, 32'd2);
        send_word(ble_pkg::CMD_FIND, 32'd2);
        send_word(ble_pkg::CMD_POP_FRONT, 32'd0);
    endtask

    // The list is filled to the brim. Pushes on a full list must fail, and a
    // find reaches the last position. Then the list is drained past empty.
    task automatic test_full_list();
        while (list_count < LIST_DEPTH) begin
            send_word($urandom_range(0, 1) ? ble_pkg::CMD_PUSH_FRONT
                                           : ble_pkg::CMD_PUSH_BACK, $urandom());
        end
        send_word(ble_pkg::CMD_PUSH_FRONT, 32'd7);
        send_word(ble_pkg::CMD_PUSH_BACK, 32'd7);
        send_word(ble_pkg::CMD_FIND, list_store[slot_at(LIST_DEPTH - 1)]);
        send_word(ble_pkg::CMD_REVERSE, 32'd0);
        send_word(ble_pkg::CMD_FIND, list_store[slot_at(LIST_DEPTH - 1)]);
        send_word(CMD_UNUSED_LAST, 32'd0);
        while (list_count > 0) begin
            send_word(ble_pkg::CMD_POP_FRONT, $urandom());
        end
        send_word(ble_pkg::CMD_POP_FRONT, 32'd0);
    endtask

    // Random commands. The push share sets whether the list tends to fill
    // up or to drain. The other commands split what is left.
    task automatic test_random_phase(input int word_total, input int push_pct);
        int          roll;
        logic [2:0]  cmd;
        for (int n = 0; n < word_total; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                cmd = $urandom_range(0, 1) ? ble_pkg::CMD_PUSH_FRONT
                                           : ble_pkg::CMD_PUSH_BACK;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    cmd = ble_pkg::CMD_POP_FRONT;
                end else if (roll < 75) begin
                    cmd = ble_pkg::CMD_FIND;
                end else if (roll < 92) begin
                    cmd = ble_pkg::CMD_REVERSE;
                end else begin
                    cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
                end
            end
            send_word(cmd, pick_value(cmd == ble_pkg::CMD_FIND ? 60 : 20));
        end
    endtask

    // After the last word, start drops. The run waits for every expected
    // result, plus a tail in which a stray word would still show up. A word
    // still expected after that is an error.
    task automatic finish_run();
        ble_pkg::t_ble_out exp_word;
        start <= 1'b0;
        for (int n = 0; n < 4 * TAIL_CYCLES && pending_results.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (pending_results.size() != 0) begin
            exp_word = pending_results.pop_front();
            $display("%0t: result word expected %p actual none", $time, exp_word);
            error_count++;
        end
    endtask

    // The main sequence runs reset, the directed tests and the random phases,
    // then gives the verdict.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_extreme_values();
        test_full_list();

        // Rounds of filling and draining move the count from empty to full
        // and back, with reverses that shift the head throughout.
        for (int round = 0; round < 4; round++) begin
            test_random_phase(170, 70);
            test_random_phase(140, 25);
        end

        finish_run();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
